>>> rtl/guest_exception_combiner_core_defines.svh
// ----------------------------------------------------------------------------
// Guest exception combiner assertion macros
// Concurrent assertion helpers for the combiner RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef GUEST_EXCEPTION_COMBINER_CORE_DEFINES_SVH
`define GUEST_EXCEPTION_COMBINER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("guest exception combiner check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("guest exception combiner check failed");
`else
`define GEC_ASSERT_NOW(label, ante, cons)
`define GEC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/gec_pkg.sv
// ----------------------------------------------------------------------------
// Guest exception combiner package
// Word types, command codes, flag positions and x86 vector class helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package gec_pkg;

    typedef enum logic [1:0] {
        CMD_QUEUE     = 2'd0,
        CMD_REQUEST   = 2'd1,
        CMD_VECTORING = 2'd2,
        CMD_SERVICE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CLS_BENIGN  = 2'd1,
        CLS_CONTRIB = 2'd2,
        CLS_PF      = 2'd3
    } exc_class_t;

    localparam int unsigned FLAGS_W = 6;

    // Request flag positions
    localparam int unsigned FLAG_INIT   = 0;
    localparam int unsigned FLAG_LAPIC  = 1;
    localparam int unsigned FLAG_EPT    = 2;
    localparam int unsigned FLAG_NMI    = 3;
    localparam int unsigned FLAG_EXC    = 4;
    localparam int unsigned FLAG_TRIPLE = 5;

    localparam logic [4:0] VEC_DE  = 5'd0;
    localparam logic [4:0] VEC_DB  = 5'd1;
    localparam logic [4:0] VEC_NMI = 5'd2;
    localparam logic [4:0] VEC_BP  = 5'd3;
    localparam logic [4:0] VEC_OF  = 5'd4;
    localparam logic [4:0] VEC_DF  = 5'd8;
    localparam logic [4:0] VEC_TS  = 5'd10;
    localparam logic [4:0] VEC_NP  = 5'd11;
    localparam logic [4:0] VEC_SS  = 5'd12;
    localparam logic [4:0] VEC_GP  = 5'd13;
    localparam logic [4:0] VEC_PF  = 5'd14;
    localparam logic [4:0] VEC_AC  = 5'd17;
    localparam logic [4:0] VEC_MC  = 5'd18;
    localparam logic [4:0] VEC_VE  = 5'd20;

    localparam logic [2:0] TYPE_NMI    = 3'd2;
    localparam logic [2:0] TYPE_HW_EXC = 3'd3;

    typedef struct packed {
        cmd_t        cmd;
        logic [4:0]  vector;
        logic [31:0] error_code;
        logic [1:0]  request_id;
        logic [31:0] vectoring_info;
    } item_t;

    typedef struct packed {
        logic        status;
        logic        do_init_vmcs;
        logic        do_lapic_reset;
        logic        do_ept_flush;
        logic        write_error;
        logic [31:0] error_out;
        logic        write_entry;
        logic [31:0] entry_info;
        logic        retain_rip;
        logic        set_resume_flag;
    } result_t;

    function automatic exc_class_t cls_of(input logic [4:0] v);
        exc_class_t c;
        case (v)
            VEC_DE, VEC_TS, VEC_NP, VEC_SS, VEC_GP: c = CLS_CONTRIB;
            VEC_PF, VEC_VE:                         c = CLS_PF;
            default:                                c = CLS_BENIGN;
        endcase
        return c;
    endfunction

    function automatic logic has_error(input logic [4:0] v);
        logic e;
        case (v)
            VEC_DF, VEC_TS, VEC_NP, VEC_SS, VEC_GP, VEC_PF, VEC_AC: e = 1'b1;
            default:                                                e = 1'b0;
        endcase
        return e;
    endfunction

    function automatic logic is_fault(input logic [4:0] v);
        logic f;
        case (v)
            VEC_NMI, VEC_DB, VEC_BP, VEC_OF, VEC_DF, VEC_MC: f = 1'b0;
            default:                                         f = 1'b1;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gec_if.sv
// ----------------------------------------------------------------------------
// Guest exception combiner channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface gec_item_if;
    import gec_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gec_result_if;
    import gec_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/guest_exception_combiner_core.sv
// ----------------------------------------------------------------------------
// Guest exception combiner core
// Merges queued guest exceptions by x86 class rules and services requests.
// ----------------------------------------------------------------------------
// Each accepted command word's result word is registered and offered in the next cycle.
// Throughput: one command word per cycle while result.ready holds; the single
//   result register is the only stage; it reloads on the edge its word is taken.
// Reset (rst_n low, asynchronous): no exception pending, all request flags
//   clear, saved vectoring info zero, result register empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "guest_exception_combiner_core_defines.svh"

module guest_exception_combiner_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    gec_item_if.sink     item,
    gec_result_if.source result
);
    import gec_pkg::*;

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic               pend_valid_reg,   pend_valid_next;
    logic [4:0]         pend_vector_reg,  pend_vector_next;
    logic [31:0]        pend_error_reg,   pend_error_next;
    logic [FLAGS_W-1:0] flags_reg,        flags_next;
    logic [31:0]        saved_vec_reg,    saved_vec_next;

    // Result register (output stage)
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;

    // Queue path scratch
    exc_class_t  pend_cls;
    exc_class_t  new_cls;
    logic [4:0]  q_vec;
    logic [31:0] q_err;

    // Service path scratch
    logic [4:0]  sv_vec;
    logic        sv_deliver;

    logic accept;

    // Take a new word whenever the output stage is empty or drains this cycle.
    assign item.ready   = !res_valid_reg || result.ready;
    assign accept       = item.valid && item.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    // Class of what is pending; an empty slot counts as benign.
    assign pend_cls = pend_valid_reg ? cls_of(pend_vector_reg) : CLS_BENIGN;
    assign new_cls  = cls_of(item.data.vector);

    // Service sees vector 0 when the slot is empty.
    assign sv_vec     = pend_valid_reg ? pend_vector_reg : 5'd0;
    assign sv_deliver = has_error(sv_vec);

    // ------------------------------------------------------------------
    // Command decode and state update
    // ------------------------------------------------------------------
    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_vector_next = pend_vector_reg;
        pend_error_next  = pend_error_reg;
        flags_next       = flags_reg;
        saved_vec_next   = saved_vec_reg;
        res_next         = '0;
        q_vec            = item.data.vector;
        q_err            = item.data.error_code;

        unique case (item.data.cmd)
            CMD_QUEUE:
            begin
                if (pend_valid_reg && (pend_vector_reg == VEC_DF) &&
                    (new_cls != CLS_BENIGN))
                begin
                    // Fault on top of a pending double fault: shut down.
                    flags_next[FLAG_TRIPLE] = 1'b1;
                end
                else
                begin
                    // Contributory on contributory, or non-benign after a
                    // page fault, folds into a double fault with error 0.
                    if (((pend_cls == CLS_CONTRIB) && (new_cls == CLS_CONTRIB)) ||
                        ((pend_cls == CLS_PF) && (new_cls != CLS_BENIGN)))
                    begin
                        q_vec = VEC_DF;
                        q_err = '0;
                    end
                    pend_valid_next       = 1'b1;
                    pend_vector_next      = q_vec;
                    pend_error_next       = has_error(q_vec) ? q_err : '0;
                    flags_next[FLAG_EXC]  = 1'b1;
                end
            end

            CMD_REQUEST:
            begin
                flags_next = flags_reg | (FLAGS_W'(1) << item.data.request_id);
            end

            CMD_VECTORING:
            begin
                saved_vec_next = item.data.vectoring_info;
            end

            CMD_SERVICE:
            begin
                if (flags_reg[FLAG_INIT])
                begin
                    flags_next[FLAG_INIT] = 1'b0;
                    res_next.do_init_vmcs = 1'b1;
                end

                if (flags_reg[FLAG_TRIPLE])
                begin
                    // Report shutdown only; leave the pending slot alone.
                    flags_next[FLAG_TRIPLE] = 1'b0;
                    res_next.status         = 1'b1;
                end
                else
                begin
                    if (flags_reg[FLAG_LAPIC])
                    begin
                        flags_next[FLAG_LAPIC]  = 1'b0;
                        res_next.do_lapic_reset = 1'b1;
                    end
                    if (flags_reg[FLAG_EPT])
                    begin
                        flags_next[FLAG_EPT]  = 1'b0;
                        res_next.do_ept_flush = 1'b1;
                    end

                    if (flags_reg[FLAG_EXC])
                    begin
                        // Inject the pending hardware exception.
                        flags_next[FLAG_EXC] = 1'b0;
                        pend_valid_next      = 1'b0;
                        if (sv_deliver)
                        begin
                            res_next.write_error = 1'b1;
                            res_next.error_out   = pend_error_reg;
                        end
                        res_next.write_entry = 1'b1;
                        res_next.entry_info  = {1'b1, 19'd0, sv_deliver, TYPE_HW_EXC,
                                                3'd0, sv_vec};
                        if (is_fault(sv_vec))
                        begin
                            res_next.retain_rip      = 1'b1;
                            res_next.set_resume_flag = 1'b1;
                        end
                    end
                    else if (flags_reg[FLAG_NMI])
                    begin
                        flags_next[FLAG_NMI] = 1'b0;
                        res_next.write_entry = 1'b1;
                        res_next.entry_info  = {1'b1, 19'd0, 1'b0, TYPE_NMI,
                                                3'd0, VEC_NMI};
                    end
                    else if (saved_vec_reg[31])
                    begin
                        // Replay the interrupted delivery word as saved.
                        res_next.write_entry = 1'b1;
                        res_next.entry_info  = saved_vec_reg;
                        saved_vec_next       = '0;
                    end
                end
            end

            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            pend_vector_reg <= '0;
            pend_error_reg  <= '0;
            flags_reg       <= '0;
            saved_vec_reg   <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_valid_reg  <= pend_valid_next;
                pend_vector_reg <= pend_vector_next;
                pend_error_reg  <= pend_error_next;
                flags_reg       <= flags_next;
                saved_vec_reg   <= saved_vec_next;
                res_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload holds until replaced by the next accepted word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `GEC_ASSERT_NOW(a_pend_tracks_exc_flag, 1'b1, pend_valid_reg == flags_reg[FLAG_EXC])
    `GEC_ASSERT_NOW(a_error_needs_entry, res_valid_reg && res_reg.write_error,
                    res_reg.write_entry)
    `GEC_ASSERT_NOW(a_triple_blocks_inject, res_valid_reg && res_reg.status,
                    !res_reg.write_entry && !res_reg.do_lapic_reset && !res_reg.do_ept_flush)
    `GEC_ASSERT_NEXT(a_plain_cmd_quiet, accept && (item.data.cmd != CMD_SERVICE),
                     res_valid_reg && (res_reg == '0))

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Guest exception combiner testbench
// Drives command words into the combiner over a valid/ready channel and checks
// every result word against a cycle-free predictor of the exception merging
// and request servicing rules. A directed opening covers the class rules and
// service priorities; a long random part follows, mostly as short episodes of
// flags, exceptions and services. Both sides idle at random. The receiver
// holds off once for a long stretch, and the sender drains twice.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import gec_pkg::*;

    localparam int unsigned RANDOM_WORDS = 1900;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 160;
    localparam int unsigned HOLD_AT      = 400;
    localparam int unsigned CALM_FROM    = 800;
    localparam int unsigned CALM_TO      = 1100;
    localparam int unsigned TAIL_CYCLES  = 10;

    typedef struct {
        item_t w;
        bit    drain_first;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n;

    gec_item_if   item_ch ();
    gec_result_if result_ch ();

    guest_exception_combiner_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always #6 clk = ~clk;

    // Command words waiting to be offered, and result words predicted for
    // the words already accepted, oldest first.
    pending_t cmd_backlog[$];
    result_t  predicted_words[$];

    int  words_in   = 0;
    int  mismatches = 0;
    int  cycles     = 0;
    bit  drain_next = 1'b0;
    logic calm;

    // No idling on either side while this window of words goes through.
    assign calm = (words_in >= CALM_FROM) && (words_in < CALM_TO);

    // Predictor state, reset values.
    logic                 held_valid  = 1'b0;
    logic [4:0]           held_vec    = '0;
    logic [31:0]          held_err    = '0;
    logic [FLAGS_W-1:0]   req_flags   = '0;
    logic [31:0]          saved_vinfo = '0;

    function automatic exc_class_t class_of_vector(input logic [4:0] v);
        if (v inside {VEC_DE, VEC_TS, VEC_NP, VEC_SS, VEC_GP})
            return CLS_CONTRIB;
        if (v inside {VEC_PF, VEC_VE})
            return CLS_PF;
        return CLS_BENIGN;
    endfunction

    function automatic logic pushes_error(input logic [4:0] v);
        return v inside {VEC_DF, VEC_TS, VEC_NP, VEC_SS, VEC_GP, VEC_PF, VEC_AC};
    endfunction

    // Traps and aborts advance RIP; everything else is injected as a fault.
    function automatic logic keeps_rip(input logic [4:0] v);
        return !(v inside {VEC_NMI, VEC_DB, VEC_BP, VEC_OF, VEC_DF, VEC_MC});
    endfunction

    // Apply one command word to the predictor state and return the result
    // word it must produce.
    function automatic result_t apply_command(input item_t w);
        result_t    r;
        exc_class_t held_cls;
        exc_class_t new_cls;
        logic [4:0] v;
        logic [31:0] e;
        logic       err_bit;

        r = '0;
        case (w.cmd)
            CMD_QUEUE:
            begin
                v = w.vector;
                e = w.error_code;
                held_cls = held_valid ? class_of_vector(held_vec) : CLS_BENIGN;
                new_cls  = class_of_vector(v);
                if (held_valid && held_vec == VEC_DF && new_cls != CLS_BENIGN)
                begin
                    // Second fault on top of a double fault: shut down, keep
                    // the double fault as it is.
                    req_flags[FLAG_TRIPLE] = 1'b1;
                end
                else
                begin
                    if ((held_cls == CLS_CONTRIB && new_cls == CLS_CONTRIB) ||
                        (held_cls == CLS_PF && new_cls != CLS_BENIGN))
                    begin
                        v = VEC_DF;
                        e = '0;
                    end
                    held_valid = 1'b1;
                    held_vec   = v;
                    held_err   = pushes_error(v) ? e : 32'd0;
                    req_flags[FLAG_EXC] = 1'b1;
                end
            end
            CMD_REQUEST:
            begin
                // Request codes line up with the low four flag positions.
                req_flags[w.request_id] = 1'b1;
            end
            CMD_VECTORING:
            begin
                saved_vinfo = w.vectoring_info;
            end
            default:
            begin
                if (req_flags[FLAG_INIT])
                begin
                    req_flags[FLAG_INIT] = 1'b0;
                    r.do_init_vmcs = 1'b1;
                end
                if (req_flags[FLAG_TRIPLE])
                begin
                    req_flags[FLAG_TRIPLE] = 1'b0;
                    r.status = 1'b1;
                end
                else
                begin
                    if (req_flags[FLAG_LAPIC])
                    begin
                        req_flags[FLAG_LAPIC] = 1'b0;
                        r.do_lapic_reset = 1'b1;
                    end
                    if (req_flags[FLAG_EPT])
                    begin
                        req_flags[FLAG_EPT] = 1'b0;
                        r.do_ept_flush = 1'b1;
                    end
                    if (req_flags[FLAG_EXC])
                    begin
                        v = held_valid ? held_vec : 5'd0;
                        err_bit = pushes_error(v);
                        req_flags[FLAG_EXC] = 1'b0;
                        if (err_bit)
                        begin
                            r.write_error = 1'b1;
                            r.error_out   = held_err;
                        end
                        r.write_entry = 1'b1;
                        r.entry_info  = {1'b1, 19'd0, err_bit, TYPE_HW_EXC, 3'd0, v};
                        held_valid = 1'b0;
                        if (keeps_rip(v))
                        begin
                            r.retain_rip      = 1'b1;
                            r.set_resume_flag = 1'b1;
                        end
                    end
                    else if (req_flags[FLAG_NMI])
                    begin
                        req_flags[FLAG_NMI] = 1'b0;
                        r.write_entry = 1'b1;
                        r.entry_info  = {1'b1, 19'd0, 1'b0, TYPE_NMI, 3'd0, VEC_NMI};
                    end
                    else if (saved_vinfo[31])
                    begin
                        // Replay the interrupted event word unchanged.
                        r.write_entry = 1'b1;
                        r.entry_info  = saved_vinfo;
                        saved_vinfo   = '0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Queue one command word; a pending drain request rides on it.
    task automatic push_word(input cmd_t c, input logic [4:0] v, input logic [31:0] e,
                             input logic [1:0] rid, input logic [31:0] vi);
        pending_t p;
        p.w.cmd            = c;
        p.w.vector         = v;
        p.w.error_code     = e;
        p.w.request_id     = rid;
        p.w.vectoring_info = vi;
        p.drain_first      = drain_next;
        drain_next         = 1'b0;
        cmd_backlog.push_back(p);
    endtask

    // Bias vectors toward the ones the class rules care about.
    function automatic logic [4:0] pick_vector();
        logic [4:0] hot[14];
        hot = '{VEC_DE, VEC_DF, VEC_TS, VEC_NP, VEC_SS, VEC_GP, VEC_PF,
                VEC_AC, VEC_MC, VEC_VE, VEC_DB, VEC_NMI, VEC_BP, VEC_OF};
        if ($urandom_range(1) == 0)
            return hot[$urandom_range(13)];
        return 5'($urandom_range(31));
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    // Sender: retire the word taken at this edge into the predictor, then
    // offer the next one unless idling or waiting for a drain. Hold the word
    // steady while the block stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predicted_words.push_back(apply_command(item_ch.data));
                void'(cmd_backlog.pop_front());
                words_in++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (cmd_backlog.size() == 0)
                    item_ch.valid <= 1'b0;
                else if (cmd_backlog[0].drain_first && predicted_words.size() != 0)
                    item_ch.valid <= 1'b0;
                else if (!calm && $urandom_range(99) < 38)
                    item_ch.valid <= 1'b0;
                else
                begin
                    item_ch.valid <= 1'b1;
                    item_ch.data  <= cmd_backlog[0].w;
                end
            end
        end
    end

    // Receiver: compare the word taken at this edge with the oldest
    // prediction, then pick ready for the next cycle. Once, drop ready for a
    // long stretch so the result register fills and the input stalls.
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (predicted_words.size() == 0)
                begin
                    $error("result word arrived with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = predicted_words.pop_front();
                    check_field("status", 32'(want.status),
                                32'(result_ch.data.status));
                    check_field("do_init_vmcs", 32'(want.do_init_vmcs),
                                32'(result_ch.data.do_init_vmcs));
                    check_field("do_lapic_reset", 32'(want.do_lapic_reset),
                                32'(result_ch.data.do_lapic_reset));
                    check_field("do_ept_flush", 32'(want.do_ept_flush),
                                32'(result_ch.data.do_ept_flush));
                    check_field("write_error", 32'(want.write_error),
                                32'(result_ch.data.write_error));
                    check_field("error_out", want.error_out, result_ch.data.error_out);
                    check_field("write_entry", 32'(want.write_entry),
                                32'(result_ch.data.write_entry));
                    check_field("entry_info", want.entry_info, result_ch.data.entry_info);
                    check_field("retain_rip", 32'(want.retain_rip),
                                32'(result_ch.data.retain_rip));
                    check_field("set_resume_flag", 32'(want.set_resume_flag),
                                32'(result_ch.data.set_resume_flag));
                end
            end
            if (!hold_done && words_in >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (calm)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= 38);
        end
    end

    // Watchdog: end a run that stops making progress.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int target;
        int n;
        bit mid_drain_done;

        mid_drain_done = 1'b0;
        rst_n          = 1'b0;

        // Directed opening.
        // Empty service: nothing to inject.
        push_word(CMD_SERVICE, 5'd0, 32'd0, 2'd0, 32'd0);
        // Saved word without its valid bit is not replayed; with it, it is.
        push_word(CMD_VECTORING, 5'd31, 32'hFFFF_FFFF, 2'd3, 32'h7FFF_FFFF);
        push_word(CMD_SERVICE, 5'd0, 32'd0, 2'd0, 32'd0);
        push_word(CMD_VECTORING, 5'd0, 32'd0, 2'd0, 32'hFFFF_FFFF);
        push_word(CMD_SERVICE, 5'd31, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
        // Two contributory faults merge into a double fault with error 0,
        // then a page fault on top of it shuts down.
        push_word(CMD_QUEUE, VEC_DE, 32'hFFFF_FFFF, 2'd0, 32'd0);
        push_word(CMD_QUEUE, VEC_GP, 32'h0000_1234, 2'd0, 32'd0);
        push_word(CMD_QUEUE, VEC_PF, 32'hDEAD_BEEF, 2'd0, 32'd0);
        // Shutdown service still fires init; the double fault stays pending.
        push_word(CMD_REQUEST, 5'd0, 32'd0, 2'd0, 32'd0);
        push_word(CMD_REQUEST, 5'd0, 32'd0, 2'd1, 32'd0);
        push_word(CMD_SERVICE, 5'd0, 32'd0, 2'd0, 32'd0);
        push_word(CMD_SERVICE, 5'd0, 32'd0, 2'd0, 32'd0);
        // Page fault then a page-fault class vector: double fault. A benign
        // vector then replaces the double fault.
        push_word(CMD_QUEUE, VEC_PF, 32'hFFFF_FFFF, 2'd0, 32'd0);
        push_word(CMD_QUEUE, VEC_VE, 32'h5555_AAAA, 2'd0, 32'd0);
        push_word(CMD_QUEUE, 5'd31, 32'hFFFF_FFFF, 2'd0, 32'd0);
        push_word(CMD_SERVICE, 5'd0, 32'd0, 2'd0, 32'd0);
        // Page fault followed by a benign NMI vector: plain replacement.
        push_word(CMD_QUEUE, VEC_PF, 32'h0000_0001, 2'd0, 32'd0);
        push_word(CMD_QUEUE, VEC_NMI, 32'hFFFF_FFFF, 2'd0, 32'd0);
        push_word(CMD_SERVICE, 5'd0, 32'd0, 2'd0, 32'd0);
        // EPT flush and NMI injection at once, with NMI injection ahead of a saved word.
        push_word(CMD_REQUEST, 5'd0, 32'd0, 2'd2, 32'd0);
        push_word(CMD_REQUEST, 5'd0, 32'd0, 2'd3, 32'd0);
        push_word(CMD_VECTORING, 5'd0, 32'd0, 2'd0, 32'h8000_0B0E);
        push_word(CMD_SERVICE, 5'd0, 32'd0, 2'd0, 32'd0);
        // Alignment check carries an error code and is a fault; the saved
        // word waits for the service after it.
        push_word(CMD_QUEUE, VEC_AC, 32'h8000_0000, 2'd0, 32'd0);
        push_word(CMD_SERVICE, 5'd0, 32'd0, 2'd0, 32'd0);
        push_word(CMD_SERVICE, 5'd0, 32'd0, 2'd0, 32'd0);

        // Random part: let the directed words settle out before it starts.
        drain_next = 1'b1;
        target = cmd_backlog.size() + RANDOM_WORDS;
        while (cmd_backlog.size() < target)
        begin
            // Pause the sender once more in the middle of the run.
            if (!mid_drain_done && cmd_backlog.size() >= 1200)
            begin
                mid_drain_done = 1'b1;
                drain_next     = 1'b1;
            end
            if ($urandom_range(99) < 60)
            begin
                // Episode: up to two flags, maybe a saved word, one to three
                // exceptions, then one or two services.
                n = $urandom_range(2);
                repeat (n)
                    push_word(CMD_REQUEST, pick_vector(), $urandom(),
                              2'($urandom_range(3)), $urandom());
                if ($urandom_range(3) == 0)
                    push_word(CMD_VECTORING, pick_vector(), $urandom(),
                              2'($urandom_range(3)), $urandom());
                n = $urandom_range(1, 3);
                repeat (n)
                    push_word(CMD_QUEUE, pick_vector(), $urandom(),
                              2'($urandom_range(3)), $urandom());
                n = $urandom_range(1, 2);
                repeat (n)
                    push_word(CMD_SERVICE, pick_vector(), $urandom(),
                              2'($urandom_range(3)), $urandom());
            end
            else
            begin
                push_word(cmd_t'($urandom_range(3)), 5'($urandom_range(31)), $urandom(),
                          2'($urandom_range(3)), $urandom());
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to go in and every prediction to be met, then
        // leave room for stray result words to show up.
        while (cmd_backlog.size() != 0 || predicted_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (predicted_words.size() != 0)
        begin
            $error("%0d predicted result words never arrived", predicted_words.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/gec_pkg.sv
rtl/gec_if.sv
rtl/guest_exception_combiner_core.sv
verif/tb.sv
